@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define UPD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent at the same edge
`define UPD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent at the next edge
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/upd_pkg.sv @@
// ---------------------------------------------------------------------------
// upd_pkg
// shared types, character codes and parse modes of the parameter decoder
// ---------------------------------------------------------------------------
package upd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned MODE_W = 3;
	localparam int unsigned NIB_W  = 4;

	// parse modes
	localparam logic [MODE_W-1:0] MODE_BETWEEN = 3'd0;
	localparam logic [MODE_W-1:0] MODE_KEY     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_VALUE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HEX_HI  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HEX_LO  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SKIP    = 3'd5;

	// special characters
	localparam logic [BYTE_W-1:0] CH_EQ   = 8'h3D; // '='
	localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26; // '&'
	localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B; // ';'
	localparam logic [BYTE_W-1:0] CH_PCT  = 8'h25; // '%'

	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] data;
		logic              last;
	} upd_item_t;

	typedef struct packed {
		logic              out_valid;
		logic [BYTE_W-1:0] out_byte;
		logic              out_in_value;
		logic              pair_end;
		logic              pair_has_value;
		logic              error_flag;
		logic              done_res;
	} upd_res_t;

	function automatic logic is_delim(input logic [BYTE_W-1:0] c);
		return (c == CH_AMP) || (c == CH_SEMI);
	endfunction

	// {not hex, digit value}
	function automatic logic [NIB_W:0] hex_val(input logic [BYTE_W-1:0] c);
		logic [NIB_W:0] r;
		r = {1'b1, {NIB_W{1'b0}}};
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b0, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

@@ hdl/url_param_list_decoder.sv @@
// ---------------------------------------------------------------------------
// url_param_list_decoder
// streaming percent-decoder for key=value lists separated by '&' or ';'
// ---------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  ------------------------------------------
//  in       in_valid / in_stall    in_byte, in_last
//  result   res_valid / res_stall  out_valid, out_byte, out_in_value,
//                                  pair_end, pair_has_value, error_flag,
//                                  done_res
//
//  one result beat per input beat, one beat per cycle sustained while res_stall is low
//  path: input register, decode, result register
//  parse state advances only when a beat moves into the result register
//  in_stall rises only while the input register is full and the result
//  register is held by res_stall
//  arst_n clears valids and the parse state; payload registers are not reset
//
`include "assert_macros.svh"

module url_param_list_decoder import upd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output logic              out_valid,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_in_value,
	output logic              pair_end,
	output logic              pair_has_value,
	output logic              error_flag,
	output logic              done_res
);

	upd_item_t item;
	upd_res_t  res_d;
	upd_res_t  res_s2;
	logic      vld_s2;
	logic      adv;     // result register free or being drained
	logic      fire;    // held input beat moves into the result register

	assign adv  = !vld_s2 || !res_stall;
	assign fire = item.vld && adv;

	upd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.adv      (adv),
		.item     (item)
	);

	upd_decode u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.fire   (fire),
		.res    (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= item.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid      = vld_s2;
	assign out_valid      = res_s2.out_valid;
	assign out_byte       = res_s2.out_byte;
	assign out_in_value   = res_s2.out_in_value;
	assign pair_end       = res_s2.pair_end;
	assign pair_has_value = res_s2.pair_has_value;
	assign error_flag     = res_s2.error_flag;
	assign done_res       = res_s2.done_res;

	// backpressure only ever comes from a held result beat
	`UPD_ASSERT_IMPL(a_stall_cause, in_stall, res_valid && res_stall,
		"input stalled without result backpressure")
	// has-value is only reported with a pair close
	`UPD_ASSERT_IMPL(a_phv_with_end, res_valid && pair_has_value, pair_end,
		"pair_has_value without pair_end")
	// key/value tag only with a decoded byte
	`UPD_ASSERT_IMPL(a_tag_with_byte, res_valid && out_in_value, out_valid,
		"out_in_value without out_valid")

endmodule

@@ hdl/upd_in_stage.sv @@
// ---------------------------------------------------------------------------
// upd_in_stage
// input register: captures one encoded byte beat ahead of the decoder
// ---------------------------------------------------------------------------
module upd_in_stage import upd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	input  logic              adv,      // downstream takes the held beat
	output upd_item_t         item
);

	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              take;

	assign in_stall = vld_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	assign item = '{vld: vld_s1, data: byte_s1, last: last_s1};

endmodule

@@ hdl/upd_decode.sv @@
// ---------------------------------------------------------------------------
// upd_decode
// parse state and single-pass decode of one byte into one result
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module upd_decode import upd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  upd_item_t item,
	input  logic      fire,     // item leaves for the result register
	output upd_res_t  res
);

	logic [MODE_W-1:0] mode_q,  mode_d;
	logic [NIB_W-1:0]  nib_q,   nib_d;
	logic              inval_q, inval_d;
	logic              open_q,  open_d;
	logic              err_q,   err_d;

	logic              emit, close, fail;
	logic [NIB_W:0]    hv;
	logic [BYTE_W-1:0] ch;

	always_comb begin
		mode_d  = mode_q;
		nib_d   = nib_q;
		inval_d = inval_q;
		open_d  = open_q;
		err_d   = err_q;
		emit    = 1'b0;
		close   = 1'b0;
		fail    = 1'b0;
		ch      = item.data;
		hv      = hex_val(item.data);
		res     = '0;

		case (mode_q)
			MODE_BETWEEN: begin
				if (is_delim(item.data)) begin
					// leading or repeated delimiter
				end else if (item.data == CH_EQ) begin
					fail = 1'b1;
				end else begin
					open_d  = 1'b1;
					inval_d = 1'b0;
					if (item.data == CH_PCT) begin
						mode_d = MODE_HEX_HI;
					end else begin
						mode_d = MODE_KEY;
						emit   = 1'b1;
					end
				end
			end
			MODE_KEY: begin
				if (is_delim(item.data)) begin
					close = 1'b1;
				end else if (item.data == CH_EQ) begin
					inval_d = 1'b1;
					mode_d  = MODE_VALUE;
				end else if (item.data == CH_PCT) begin
					mode_d = MODE_HEX_HI;
				end else begin
					emit = 1'b1;
				end
			end
			MODE_VALUE: begin
				if (is_delim(item.data)) begin
					close = 1'b1;
				end else if (item.data == CH_PCT) begin
					mode_d = MODE_HEX_HI;
				end else begin
					emit = 1'b1;
				end
			end
			MODE_HEX_HI: begin
				if (hv[NIB_W]) begin
					fail = 1'b1;
				end else begin
					nib_d  = hv[NIB_W-1:0];
					mode_d = MODE_HEX_LO;
				end
			end
			MODE_HEX_LO: begin
				if (hv[NIB_W]) begin
					fail = 1'b1;
				end else begin
					ch     = {nib_q, hv[NIB_W-1:0]};
					emit   = 1'b1;
					mode_d = inval_q ? MODE_VALUE : MODE_KEY;
				end
			end
			default: begin
				// skipping after error
			end
		endcase

		if (emit) begin
			res.out_valid    = 1'b1;
			res.out_byte     = ch;
			res.out_in_value = inval_d;
		end
		if (close) begin
			res.pair_end       = 1'b1;
			res.pair_has_value = inval_d;
			mode_d  = MODE_BETWEEN;
			open_d  = 1'b0;
			inval_d = 1'b0;
		end
		if (fail) begin
			err_d  = 1'b1;
			mode_d = MODE_SKIP;
			open_d = 1'b0;
		end

		if (item.last) begin
			if (mode_d == MODE_KEY || mode_d == MODE_VALUE) begin
				res.pair_end       = 1'b1;
				res.pair_has_value = inval_d;
			end else if (mode_d == MODE_HEX_HI || mode_d == MODE_HEX_LO) begin
				// escape cut short by end of string
				err_d = 1'b1;
			end
			res.done_res = 1'b1;
		end
		res.error_flag = err_d;

		if (item.last) begin
			mode_d  = MODE_BETWEEN;
			nib_d   = '0;
			inval_d = 1'b0;
			open_d  = 1'b0;
			err_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BETWEEN;
			nib_q   <= '0;
			inval_q <= 1'b0;
			open_q  <= 1'b0;
			err_q   <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_d;
			nib_q   <= nib_d;
			inval_q <= inval_d;
			open_q  <= open_d;
			err_q   <= err_d;
		end
	end

	`UPD_ASSERT_NEXT(a_last_resets, fire && item.last,
		mode_q == MODE_BETWEEN && !err_q && !open_q, "state not cleared after last beat")
	`UPD_ASSERT_IMPL(a_escape_in_pair, mode_q == MODE_HEX_HI || mode_q == MODE_HEX_LO,
		open_q, "escape pending outside an open pair")
	// a failed value keeps its flag while skipping, so skip mode is left out
	`UPD_ASSERT_IMPL(a_value_in_pair, inval_q && mode_q != MODE_SKIP, open_q,
		"value flag set with no open pair")

endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the url parameter list decoder
// ---------------------------------------------------------------------------
// Sends encoded key=value strings, one byte per beat, and predicts every
// result beat with a behavioral decoder kept inside the bench. The directed
// tests cover separators, literal '=' in values, escapes in both cases, byte
// extremes, an empty key, a bad escape and a cut-short one. A long random
// test follows. Most of its strings are well formed with random content.
// The rest are noise or strings broken by a bad or cut-short escape or a
// stray '='. Both sides insert random gaps, but for one full-rate stretch.
// ---------------------------------------------------------------------------
module tb_top;
	import upd_pkg::*;

	localparam int GAP_PCT       = 15;   // chance of an idle cycle on each side
	localparam int RANDOM_BEATS  = 650;  // byte beats in the random test
	localparam int QUIET_LIMIT   = 2000; // cycles without any beat before giving up
	localparam int DRAIN_CYCLES  = 10;   // settle time after the last result

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] in_byte   = '0;
	logic              in_last   = 1'b0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic              out_valid;
	logic [BYTE_W-1:0] out_byte;
	logic              out_in_value;
	logic              pair_end;
	logic              pair_has_value;
	logic              error_flag;
	logic              done_res;

	// bench state
	bit       gaps_on = 1'b1;  // random idling on both channels
	int       beats_sent;
	int       mismatches;
	int       quiet_cycles;
	upd_res_t pending_decodes[$];  // predicted result beats, oldest first
	upd_res_t oldest;

	// decoder state as the bench tracks it
	logic [MODE_W-1:0] dec_mode     = MODE_BETWEEN;
	logic [NIB_W-1:0]  dec_nib      = '0;
	logic              dec_in_value = 1'b0;
	logic              dec_err      = 1'b0;

	url_param_list_decoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.in_last        (in_last),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.out_valid      (out_valid),
		.out_byte       (out_byte),
		.out_in_value   (out_in_value),
		.pair_end       (pair_end),
		.pair_has_value (pair_has_value),
		.error_flag     (error_flag),
		.done_res       (done_res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// decoding helpers
	// ------------------------------------------------------------------

	// bit 4 set means the character is not a hex digit
	function automatic logic [4:0] hex_of(input logic [BYTE_W-1:0] c);
		if (c >= "0" && c <= "9") return 5'(c - "0");
		if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
		if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
		return 5'h10;
	endfunction

	function automatic logic is_separator(input logic [BYTE_W-1:0] c);
		return (c == CH_AMP) || (c == CH_SEMI);
	endfunction

	function automatic logic [BYTE_W-1:0] hex_char(input logic [NIB_W-1:0] n, input bit upper);
		if (n < 10) return 8'("0" + n);
		return upper ? 8'("A" + n - 10) : 8'("a" + n - 10);
	endfunction

	// one byte through the decoder: returns the result beat, advances state
	function automatic upd_res_t decode_step(input logic [BYTE_W-1:0] b, input logic last);
		upd_res_t          r;
		logic [4:0]        h;
		logic [BYTE_W-1:0] ch;
		logic              emit;
		logic              close;
		logic              fail;
		r     = '0;
		emit  = 1'b0;
		close = 1'b0;
		fail  = 1'b0;
		ch    = b;
		h     = hex_of(b);
		case (dec_mode)
			MODE_BETWEEN: begin
				// leading and repeated separators fall through untouched
				if (!is_separator(b)) begin
					if (b == CH_EQ) begin
						fail = 1'b1;  // empty key
					end else begin
						dec_in_value = 1'b0;
						if (b == CH_PCT) begin
							dec_mode = MODE_HEX_HI;
						end else begin
							dec_mode = MODE_KEY;
							emit     = 1'b1;
						end
					end
				end
			end
			MODE_KEY: begin
				if (is_separator(b)) begin
					close = 1'b1;
				end else if (b == CH_EQ) begin
					dec_in_value = 1'b1;
					dec_mode     = MODE_VALUE;
				end else if (b == CH_PCT) begin
					dec_mode = MODE_HEX_HI;
				end else begin
					emit = 1'b1;
				end
			end
			MODE_VALUE: begin
				// a further '=' is just data here
				if (is_separator(b)) begin
					close = 1'b1;
				end else if (b == CH_PCT) begin
					dec_mode = MODE_HEX_HI;
				end else begin
					emit = 1'b1;
				end
			end
			MODE_HEX_HI: begin
				if (h[4]) begin
					fail = 1'b1;
				end else begin
					dec_nib  = h[3:0];
					dec_mode = MODE_HEX_LO;
				end
			end
			MODE_HEX_LO: begin
				if (h[4]) begin
					fail = 1'b1;
				end else begin
					ch       = {dec_nib, h[3:0]};
					emit     = 1'b1;
					dec_mode = dec_in_value ? MODE_VALUE : MODE_KEY;
				end
			end
			default: begin
				// skipping after an error
			end
		endcase

		if (emit) begin
			r.out_valid    = 1'b1;
			r.out_byte     = ch;
			r.out_in_value = dec_in_value;
		end
		if (close) begin
			r.pair_end       = 1'b1;
			r.pair_has_value = dec_in_value;
			dec_mode         = MODE_BETWEEN;
			dec_in_value     = 1'b0;
		end
		if (fail) begin
			dec_err  = 1'b1;
			dec_mode = MODE_SKIP;
		end

		if (last) begin
			// an open pair closes on the last byte, a pending escape is cut short
			if (dec_mode == MODE_KEY || dec_mode == MODE_VALUE) begin
				r.pair_end       = 1'b1;
				r.pair_has_value = dec_in_value;
			end else if (dec_mode == MODE_HEX_HI || dec_mode == MODE_HEX_LO) begin
				dec_err = 1'b1;
			end
			r.done_res = 1'b1;
		end
		r.error_flag = dec_err;

		if (last) begin
			dec_mode     = MODE_BETWEEN;
			dec_nib      = '0;
			dec_in_value = 1'b0;
			dec_err      = 1'b0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// predicts on every input beat, checks every result beat, and watches
	// for a stuck handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_decodes = {pending_decodes, decode_step(in_byte, in_last)};

			if (res_valid && !res_stall) begin
				if (pending_decodes.size() == 0) begin
					mismatches++;
					$display("%0t: result beat expected none actual byte %0h done %0b",
						$time, out_byte, done_res);
				end else begin
					oldest = pending_decodes.pop_front();
					check_field("out_valid", oldest.out_valid, out_valid);
					check_field("out_byte", oldest.out_byte, out_byte);
					check_field("out_in_value", oldest.out_in_value, out_in_value);
					check_field("pair_end", oldest.pair_end, pair_end);
					check_field("pair_has_value", oldest.pair_has_value, pair_has_value);
					check_field("error_flag", oldest.error_flag, error_flag);
					check_field("done_res", oldest.done_res, done_res);
				end
			end

			if ((in_valid && !in_stall) || (res_valid && !res_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// receiver stalls at random while gaps are on
	always @(posedge clk)
		res_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	// one input beat; returns in the time step of the accepting edge so the
	// next call can keep valid high without a gap
	task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last);
		while (gaps_on && $urandom_range(99) < GAP_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], i == s.len() - 1);
	endtask

	// appends one byte to a string under construction
	task automatic add_byte(ref logic [BYTE_W-1:0] t[$], input logic [BYTE_W-1:0] c);
		t = {t, c};
	endtask

	// a plain data byte, or an escape with random digits and case
	task automatic push_atom(ref logic [BYTE_W-1:0] t[$], input bit allow_eq);
		logic [BYTE_W-1:0] c;
		if ($urandom_range(4) == 0) begin
			add_byte(t, CH_PCT);
			add_byte(t, hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
			add_byte(t, hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
		end else begin
			do begin
				c = 8'($urandom_range(255));
			end while (is_separator(c) || c == CH_PCT || (!allow_eq && c == CH_EQ));
			add_byte(t, c);
		end
	endtask

	task automatic test_pairs();
		// leading separators, literal '=' in a value, close on a separator
		send_text("&;k=v=w;");
		// separators only: no pair, no error
		send_text(";;");
		// byte extremes as a key that closes on the last byte
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b1);
	endtask

	task automatic test_escapes();
		// both digit cases, escape as first key byte and in a value
		send_text("%fF=%A0");
	endtask

	task automatic test_errors();
		send_text("=x");   // empty key, rest skipped
		send_text("a%&");  // separator where a hex digit belongs
		send_text("b%4");  // escape cut short by the last byte
	endtask

	task automatic test_random_lists();
		logic [BYTE_W-1:0] t[$];
		logic [BYTE_W-1:0] c;
		int                start;
		int                kind;
		int                n_pairs;
		int                pos;
		start = beats_sent;
		while (beats_sent - start < RANDOM_BEATS) begin
			// one stretch at full rate on both sides
			gaps_on = !((beats_sent - start) >= 150 && (beats_sent - start) < 320);
			t = {};
			kind = $urandom_range(99);
			if (kind < 15) begin
				// noise, biased toward the characters that steer the parser
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(5))
						0:       c = CH_EQ;
						1:       c = CH_PCT;
						2:       c = $urandom_range(1) ? CH_AMP : CH_SEMI;
						default: c = 8'($urandom_range(255));
					endcase
					add_byte(t, c);
				end
			end else begin
				if ($urandom_range(3) == 0)
					add_byte(t, $urandom_range(1) ? CH_AMP : CH_SEMI);
				n_pairs = $urandom_range(1, 4);
				for (int p = 0; p < n_pairs; p++) begin
					repeat ($urandom_range(1, 4))
						push_atom(t, 1'b0);
					if ($urandom_range(3) != 0) begin
						add_byte(t, CH_EQ);
						repeat ($urandom_range(0, 4))
							push_atom(t, 1'b1);
					end
					if (p < n_pairs - 1 || $urandom_range(1)) begin
						add_byte(t, $urandom_range(1) ? CH_AMP : CH_SEMI);
						if ($urandom_range(4) == 0)
							add_byte(t, $urandom_range(1) ? CH_AMP : CH_SEMI);
					end
				end
				// break some of the well-formed strings
				if (kind < 30) begin
					pos = $urandom_range(t.size());
					case ($urandom_range(2))
						0: add_byte(t, CH_PCT);
						1: begin
							do begin
								c = 8'($urandom_range(255));
							end while (hex_of(c) != 5'h10);
							t.insert(pos, c);
							t.insert(pos, CH_PCT);
						end
						default: t.insert(pos, CH_EQ);
					endcase
				end
			end
			foreach (t[i])
				send_beat(t[i], i == t.size() - 1);
		end
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pairs();
		test_escapes();
		test_errors();
		test_random_lists();

		in_valid <= 1'b0;
		// let the monitor take in the final beat before looking at the queue
		@(posedge clk);
		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
